@@ sv/dms_pkg.sv @@
// ----------------------------------------------------------------------------
// dms_pkg: shared types, codes and helpers of the dual motor supervisor
// Holds the request and operation codes, the queue word, the status-word
// layout and the small arithmetic helpers used by the front and back parts.
// ----------------------------------------------------------------------------
package dms_pkg;

    // Request kinds on the input channel.
    typedef enum logic [1:0] {
        REQ_CMD       = 2'd0,
        REQ_CURRENT   = 2'd1,
        REQ_UNDERVOLT = 2'd2,
        REQ_TICK      = 2'd3
    } t_req;

    // Decoded operations carried from the front part to the back part.
    typedef enum logic [3:0] {
        OP_VERSION,
        OP_VOLT,
        OP_START1,
        OP_START2,
        OP_ZERO,
        OP_STATUS,
        OP_STOP,
        OP_GEAR_READ,
        OP_SET_GEAR1,
        OP_SET_GEAR2,
        OP_SET_OPEN,
        OP_CURRENT,
        OP_UNDERVOLT,
        OP_TICK
    } t_op;

    // One queued word. The meaning of the payload fields depends on op.
    typedef struct packed {
        t_op        op;
        logic       flag;   // forward request, or motor select of a sample
        logic [2:0] level;  // gear value, or countdown seconds (zero: none)
        logic [7:0] val_a;  // corrected current, or scaled bus voltage
        logic [7:0] val_b;  // scaled current field
    } t_entry;

    // Configuration register indexes.
    localparam logic [1:0] REG_VERSION = 2'd0;

    localparam logic [7:0] VERSION_RESET = 8'h12;
    localparam logic [2:0] GEAR_RESET    = 3'd1;

    // Command groups (upper nibble) and individual command codes.
    localparam logic [3:0] GRP_VERSION = 4'hD;
    localparam logic [3:0] GRP_VOLT    = 4'h3;
    localparam logic [3:0] GRP_START1  = 4'h6;
    localparam logic [3:0] GRP_START2  = 4'h7;
    localparam logic [3:0] GRP_MISC    = 4'h8;
    localparam logic [3:0] GRP_OPEN    = 4'h9;

    localparam logic [7:0] CMD_START1_FWD  = 8'h61;
    localparam logic [7:0] CMD_START1_REV  = 8'h62;
    localparam logic [3:0] START2_LO       = 4'h1;
    localparam logic [3:0] START2_HI       = 4'hC;
    localparam logic [7:0] CMD_START2_PLAIN = 8'h72;
    localparam logic [7:0] CMD_ZERO        = 8'h80;
    localparam logic [7:0] CMD_STATUS      = 8'h81;
    localparam logic [7:0] CMD_STOP        = 8'h82;
    localparam logic [7:0] CMD_GEAR_READ   = 8'h83;
    localparam logic [7:0] CMD_GEAR2_BASE  = 8'h89;
    localparam logic [7:0] CMD_OPEN_BASE   = 8'h99;

    // Status word layout.
    localparam int         ST_RUN_BIT = 0;
    localparam int         ST_DIR_BIT = 1;
    localparam logic [15:0] ST_RUN    = 16'h0001;
    localparam logic [15:0] ST_DIR    = 16'h0002;
    localparam logic [15:0] ST_OPEN   = 16'h0004;
    localparam logic [15:0] ST_CMD    = 16'h0008;
    localparam logic [15:0] ST_OVER   = 16'h0010;
    localparam logic [15:0] ST_UV     = 16'h0020;
    localparam logic [15:0] ST_RES    = 16'h00C0;
    localparam logic [15:0] ST_CAUSES = ST_OPEN | ST_CMD | ST_OVER | ST_UV | ST_RES;

    localparam logic [1:0] RES_SAME    = 2'd1;
    localparam logic [1:0] RES_REVERSE = 2'd2;
    localparam logic [1:0] RES_BUSY    = 2'd3;

    // Fixed-point scale factors. The bus voltage is bus*0.34333 and the
    // current field a*1.087, both rounded down; these multipliers are exact
    // over the full 8-bit input range.
    localparam logic [7:0]  CUR_OFFSET = 8'd5;
    localparam logic [23:0] VOLT_MULT  = 24'd11520244;
    localparam int          VOLT_SHIFT = 25;
    localparam logic [18:0] CUR_MULT   = 19'd284951;
    localparam int          CUR_SHIFT  = 18;
    localparam logic [7:0]  VOLT_RUN_ADD = 8'd3;

    // Overcurrent limit 108 + 27*(gear-1).
    function automatic logic [7:0] f_stall_limit(input logic [2:0] gear);
        logic [7:0] lim;
        unique case (gear)
            3'd2:    lim = 8'd135;
            3'd3:    lim = 8'd162;
            3'd4:    lim = 8'd189;
            3'd5:    lim = 8'd216;
            3'd6:    lim = 8'd243;
            default: lim = 8'd108;
        endcase
        return lim;
    endfunction

    // Open-circuit limit 11*(gear-1) + 4.
    function automatic logic [7:0] f_open_limit(input logic [2:0] gear);
        logic [7:0] lim;
        unique case (gear)
            3'd2:    lim = 8'd15;
            3'd3:    lim = 8'd26;
            3'd4:    lim = 8'd37;
            3'd5:    lim = 8'd48;
            3'd6:    lim = 8'd59;
            default: lim = 8'd4;
        endcase
        return lim;
    endfunction

    function automatic logic [15:0] f_stop(input logic [15:0] s, input logic [15:0] cause);
        logic [15:0] r;
        r = s;
        if (s[ST_RUN_BIT]) begin
            r = (s & ~ST_RUN) | cause;
        end
        return r;
    endfunction

    function automatic logic [15:0] f_start(input logic [15:0] s, input logic other_run,
                                            input logic fwd);
        logic [15:0] r;
        r = s;
        if (other_run) begin
            r[7:6] = RES_BUSY;
        end else if (s[ST_RUN_BIT]) begin
            r[7:6] = (s[ST_DIR_BIT] == fwd) ? RES_SAME : RES_REVERSE;
        end else begin
            r = s & ~(ST_CAUSES | ST_DIR);
            r[ST_DIR_BIT] = fwd;
            r[ST_RUN_BIT] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [15:0] f_current(input logic [15:0] s, input logic [2:0] gear,
                                              input logic [2:0] og, input logic [7:0] a,
                                              input logic [7:0] cur);
        logic [15:0] r;
        r = s;
        if (s[ST_RUN_BIT]) begin
            if (a > f_stall_limit(gear)) begin
                r = (r & ~ST_RUN) | ST_OVER;
            end else if (a < f_open_limit(og)) begin
                r = (r & ~ST_RUN) | ST_OPEN;
            end
            r[15:8] = cur;
        end
        return r;
    endfunction

endpackage

@@ sv/dms_front.sv @@
// ----------------------------------------------------------------------------
// dms_front: request decoder
// Classifies each input word into a queued operation and does the
// state-independent arithmetic (zero offset and scaling of samples).
// ----------------------------------------------------------------------------
module dms_front
    import dms_pkg::*;
(
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_cmd_byte,
    input  logic       i_motor_sel,
    input  logic [7:0] i_current_sample,
    input  logic [7:0] i_bus_sample,
    output logic       o_keep,
    output t_entry     o_entry
);

    logic [31:0] volt_prod;
    logic [26:0] cur_prod;
    logic [8:0]  cur_full;
    logic [7:0]  cur_sat;
    logic [7:0]  corr;
    logic [3:0]  nib;
    logic [3:0]  cd_secs;
    logic [7:0]  gear1_off;
    logic [7:0]  gear2_off;
    logic [7:0]  open_off;

    assign corr      = (i_current_sample > CUR_OFFSET) ? i_current_sample - CUR_OFFSET : 8'd0;
    assign volt_prod = {24'd0, i_bus_sample} * {8'd0, VOLT_MULT};
    assign cur_prod  = {19'd0, corr} * {8'd0, CUR_MULT};
    assign cur_full  = cur_prod[CUR_SHIFT +: 9];
    assign cur_sat   = cur_full[8] ? 8'hFF : cur_full[7:0];
    assign nib       = i_cmd_byte[3:0];
    assign cd_secs   = ((nib - 4'd1) >> 1) + 4'd1;
    assign gear1_off = i_cmd_byte - CMD_GEAR_READ;
    assign gear2_off = i_cmd_byte - CMD_GEAR2_BASE;
    assign open_off  = i_cmd_byte - CMD_OPEN_BASE;

    always_comb begin
        o_keep  = 1'b0;
        o_entry = '0;
        unique case (t_req'(i_req_type))
            REQ_CMD: begin
                unique case (i_cmd_byte[7:4])
                    GRP_VERSION: begin
                        o_keep     = 1'b1;
                        o_entry.op = OP_VERSION;
                    end
                    GRP_VOLT: begin
                        o_keep        = 1'b1;
                        o_entry.op    = OP_VOLT;
                        o_entry.val_a = {1'b0, volt_prod[VOLT_SHIFT +: 7]};
                    end
                    GRP_START1: begin
                        if (i_cmd_byte == CMD_START1_FWD || i_cmd_byte == CMD_START1_REV) begin
                            o_keep       = 1'b1;
                            o_entry.op   = OP_START1;
                            o_entry.flag = (i_cmd_byte == CMD_START1_FWD);
                        end
                    end
                    GRP_START2: begin
                        if (nib >= START2_LO && nib <= START2_HI) begin
                            o_keep       = 1'b1;
                            o_entry.op   = OP_START2;
                            o_entry.flag = ~i_cmd_byte[0];
                            if (i_cmd_byte > CMD_START2_PLAIN) begin
                                o_entry.level = cd_secs[2:0];
                            end
                        end
                    end
                    GRP_MISC: begin
                        o_keep = 1'b1;
                        priority if (i_cmd_byte == CMD_ZERO) begin
                            o_entry.op = OP_ZERO;
                        end else if (i_cmd_byte == CMD_STATUS) begin
                            o_entry.op = OP_STATUS;
                        end else if (i_cmd_byte == CMD_STOP) begin
                            o_entry.op = OP_STOP;
                        end else if (i_cmd_byte == CMD_GEAR_READ) begin
                            o_entry.op = OP_GEAR_READ;
                        end else if (i_cmd_byte > CMD_GEAR2_BASE) begin
                            o_entry.op    = OP_SET_GEAR2;
                            o_entry.level = gear2_off[2:0];
                        end else begin
                            o_entry.op    = OP_SET_GEAR1;
                            o_entry.level = gear1_off[2:0];
                        end
                    end
                    GRP_OPEN: begin
                        if (i_cmd_byte > CMD_OPEN_BASE) begin
                            o_keep        = 1'b1;
                            o_entry.op    = OP_SET_OPEN;
                            o_entry.level = open_off[2:0];
                        end
                    end
                    default: begin
                        o_keep = 1'b0;
                    end
                endcase
            end
            REQ_CURRENT: begin
                o_keep        = 1'b1;
                o_entry.op    = OP_CURRENT;
                o_entry.flag  = i_motor_sel;
                o_entry.val_a = corr;
                o_entry.val_b = cur_sat;
            end
            REQ_UNDERVOLT: begin
                o_keep     = 1'b1;
                o_entry.op = OP_UNDERVOLT;
            end
            REQ_TICK: begin
                o_keep     = 1'b1;
                o_entry.op = OP_TICK;
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/dms_queue.sv @@
// ----------------------------------------------------------------------------
// dms_queue: operation queue
// Small first-in first-out buffer of decoded operations between the
// decoder and the executing back part.
// ----------------------------------------------------------------------------
module dms_queue
    import dms_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_entry o_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    // Pointers wrap at the last entry, so depths that are not a power of two work.
    always_comb begin
        n_wr_ptr = !i_push ? r_wr_ptr :
                   (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = !i_pop ? r_rd_ptr :
                   (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("operation queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("operation queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("operation queue count out of range");

endmodule

@@ sv/dms_back.sv @@
// ----------------------------------------------------------------------------
// dms_back: executor and reply buffer
// Owns the supervisor state, carries out one queued operation per cycle while
// its reply buffer is free and streams replies via a registered output buffer.
// ----------------------------------------------------------------------------
module dms_back
    import dms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_reply_byte,
    output logic       o_last
);

    logic [15:0] r_status1;
    logic [15:0] r_status2;
    logic [2:0]  r_gear1;
    logic [2:0]  r_gear2;
    logic [2:0]  r_open_gear;
    logic [2:0]  r_countdown;
    logic [7:0]  r_version;
    logic [7:0]  r_buf [4];
    logic [2:0]  r_cnt;

    logic [15:0] n_status1;
    logic [15:0] n_status2;
    logic [2:0]  n_gear1;
    logic [2:0]  n_gear2;
    logic [2:0]  n_open_gear;
    logic [2:0]  n_countdown;
    logic [7:0]  n_buf [4];
    logic [2:0]  n_cnt;

    logic [7:0]  rep [4];
    logic [2:0]  rep_len;
    logic        any_run;
    logic        out_take;

    assign o_valid      = (r_cnt != 3'd0);
    assign o_reply_byte = r_buf[0];
    assign o_last       = (r_cnt == 3'd1);
    assign out_take     = o_valid && i_ready;
    assign o_q_pop      = i_q_valid && ((r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready));
    assign any_run      = r_status1[ST_RUN_BIT] || r_status2[ST_RUN_BIT];

    // Operation execution: state update and reply assembly.
    always_comb begin
        n_status1   = r_status1;
        n_status2   = r_status2;
        n_gear1     = r_gear1;
        n_gear2     = r_gear2;
        n_open_gear = r_open_gear;
        n_countdown = r_countdown;
        rep_len     = 3'd0;
        for (int k = 0; k < 4; k++) begin
            rep[k] = 8'd0;
        end
        if (o_q_pop) begin
            unique case (i_q_entry.op)
                OP_VERSION: begin
                    rep[0]  = r_version;
                    rep_len = 3'd1;
                end
                OP_VOLT: begin
                    rep[0]  = i_q_entry.val_a + (any_run ? VOLT_RUN_ADD : 8'd0);
                    rep_len = 3'd1;
                end
                OP_START1: begin
                    n_status1 = f_start(r_status1, r_status2[ST_RUN_BIT], i_q_entry.flag);
                    rep[0]    = n_status1[7:0];
                    rep[1]    = n_status1[15:8];
                    rep_len   = 3'd2;
                end
                OP_START2: begin
                    n_status2 = f_start(r_status2, r_status1[ST_RUN_BIT], i_q_entry.flag);
                    rep[0]    = n_status2[7:0];
                    rep[1]    = n_status2[15:8];
                    rep_len   = 3'd2;
                    if (i_q_entry.level != 3'd0) begin
                        n_countdown = i_q_entry.level;
                    end
                end
                OP_ZERO: begin
                    rep_len = 3'd1;
                end
                OP_STATUS: begin
                    rep[0]  = r_status1[7:0];
                    rep[1]  = r_status1[15:8];
                    rep[2]  = r_status2[7:0];
                    rep[3]  = r_status2[15:8];
                    rep_len = 3'd4;
                end
                OP_STOP: begin
                    n_status1 = f_stop(r_status1, ST_CMD);
                    n_status2 = f_stop(r_status2, ST_CMD);
                    rep_len   = 3'd1;
                end
                OP_GEAR_READ: begin
                    rep[0]  = {1'b0, r_gear2, 1'b0, r_gear1};
                    rep[1]  = {5'd0, r_open_gear};
                    rep_len = 3'd2;
                end
                OP_SET_GEAR1: begin
                    n_gear1 = i_q_entry.level;
                    rep_len = 3'd1;
                end
                OP_SET_GEAR2: begin
                    n_gear2 = i_q_entry.level;
                    rep_len = 3'd1;
                end
                OP_SET_OPEN: begin
                    n_open_gear = i_q_entry.level;
                    rep_len     = 3'd1;
                end
                OP_CURRENT: begin
                    if (i_q_entry.flag) begin
                        n_status2 = f_current(r_status2, r_gear2, r_open_gear,
                                              i_q_entry.val_a, i_q_entry.val_b);
                    end else begin
                        n_status1 = f_current(r_status1, r_gear1, r_open_gear,
                                              i_q_entry.val_a, i_q_entry.val_b);
                    end
                end
                OP_UNDERVOLT: begin
                    n_status1 = f_stop(r_status1, ST_UV);
                    n_status2 = f_stop(r_status2, ST_UV);
                end
                OP_TICK: begin
                    if (r_countdown != 3'd0) begin
                        n_countdown = r_countdown - 3'd1;
                        if (r_countdown == 3'd1) begin
                            n_status1 = f_stop(r_status1, ST_CMD);
                            n_status2 = f_stop(r_status2, ST_CMD);
                        end
                    end
                end
                default: begin
                    rep_len = 3'd0;
                end
            endcase
        end
    end

    // Reply buffer: load on a new operation, shift out one word per take.
    always_comb begin
        n_cnt = r_cnt;
        for (int k = 0; k < 4; k++) begin
            n_buf[k] = r_buf[k];
        end
        if (o_q_pop) begin
            n_cnt = rep_len;
            for (int k = 0; k < 4; k++) begin
                n_buf[k] = rep[k];
            end
        end else if (out_take) begin
            n_cnt = r_cnt - 3'd1;
            for (int k = 0; k < 3; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status1   <= '0;
            r_status2   <= '0;
            r_gear1     <= GEAR_RESET;
            r_gear2     <= GEAR_RESET;
            r_open_gear <= GEAR_RESET;
            r_countdown <= '0;
            r_version   <= VERSION_RESET;
            r_cnt       <= '0;
        end else begin
            r_status1   <= n_status1;
            r_status2   <= n_status2;
            r_gear1     <= n_gear1;
            r_gear2     <= n_gear2;
            r_open_gear <= n_open_gear;
            r_countdown <= n_countdown;
            r_cnt       <= n_cnt;
            if (i_cfg_we && i_cfg_index == REG_VERSION) begin
                r_version <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_buf[k] <= n_buf[k];
        end
    end

    a_one_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_status1[ST_RUN_BIT] && r_status2[ST_RUN_BIT]))
        else $error("both motors running at once");

    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gear1 >= 3'd1 && r_gear1 <= 3'd6) && (r_gear2 >= 3'd1 && r_gear2 <= 3'd6)
        && (r_open_gear >= 3'd1 && r_open_gear <= 3'd6))
        else $error("gear level out of range");

    a_countdown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_countdown <= 3'd6)
        else $error("countdown out of range");

    a_reply_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && rep_len != 3'd0) |=> (o_valid && r_cnt == $past(rep_len)))
        else $error("reply words not presented after a command");

endmodule

@@ sv/dual_motor_supervisor.sv @@
// ----------------------------------------------------------------------------
// dual_motor_supervisor: supervisor of two DC motors
// Decodes host commands, current samples, undervoltage events and second
// ticks, keeps the motor status words and streams reply words to the host.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_in_valid / o_in_ready) carries one event word:
// a command byte, a current sample, an undervoltage event or a one-second
// tick, selected by i_req_type. Only commands give reply words on the output
// channel (o_out_valid / i_out_ready), one byte per word, status words low
// byte first, with o_last set on the final byte of each reply. Unknown
// commands are accepted and give no reply.
// Flow. An accepted event is written into the event queue. The executor pops
// and carries it out when its reply buffer is empty or the final word in it
// is being taken, and loads its reply words into that registered buffer.
// The executor retires one event per cycle while the buffer is free, and the
// reply buffer sends one word per cycle while the receiver is ready. The
// event queue (QUEUE_DEPTH words) decouples the decoder from the executor,
// and o_in_ready drops only when it is full, so a stalled receiver holds up
// the input only after the queue fills.
// Reset (i_rst_n, synchronous, active low) clears both status words and the
// countdown, sets all gears to 1 and the version byte to its default. The
// block keeps no boot gear registers: configuration writes to any index but
// the version register have no visible effect; they are accepted and discarded.
// ----------------------------------------------------------------------------
module dual_motor_supervisor
    import dms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // event input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_cmd_byte,
    input  logic       i_motor_sel,
    input  logic [7:0] i_current_sample,
    input  logic [7:0] i_bus_sample,
    // reply output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_reply_byte,
    output logic       o_last
);

    logic   keep;
    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_entry dec_entry;
    t_entry q_entry;

    // The decoder sees the input payload directly; an accepted word is
    // written to the queue unless it is a command that needs no action.
    assign o_in_ready = !q_full;
    assign push       = i_in_valid && o_in_ready && keep;

    dms_front u_front (
        .i_req_type      (i_req_type),
        .i_cmd_byte      (i_cmd_byte),
        .i_motor_sel     (i_motor_sel),
        .i_current_sample(i_current_sample),
        .i_bus_sample    (i_bus_sample),
        .o_keep          (keep),
        .o_entry         (dec_entry)
    );

    dms_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(dec_entry),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_entry(q_entry)
    );

    // The executor pops a new operation whenever its reply buffer is empty
    // or its final word is being taken in the same cycle.
    dms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_reply_byte(o_reply_byte),
        .o_last      (o_last)
    );

endmodule

@@ tb/sv/dms_reply_checker.sv @@
// ----------------------------------------------------------------------------
// dms_reply_checker: reply checker of the dual motor supervisor
// Watches the configuration port and both word channels, keeps its own copy
// of the motor state, works out the reply words of every accepted event and
// compares each accepted reply word with the oldest one still expected.
// ----------------------------------------------------------------------------
module dms_reply_checker
    import dms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_cmd_byte,
    input  logic       i_motor_sel,
    input  logic [7:0] i_current_sample,
    input  logic [7:0] i_bus_sample,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_reply_byte,
    input  logic       i_last,
    output int         o_errors,
    output int         o_pending,
    output int         o_events,
    output int         o_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_word_t;

    reply_word_t expected_replies[$];

    logic [15:0] status_m1;
    logic [15:0] status_m2;
    logic [2:0]  gear_m1;
    logic [2:0]  gear_m2;
    logic [2:0]  open_gear_lvl;
    logic [2:0]  fine_secs;
    logic [7:0]  version_byte;

    int mismatch_count = 0;
    int waiting_words  = 0;
    int events_seen    = 0;
    int words_seen     = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = waiting_words;
    assign o_events  = events_seen;
    assign o_words   = words_seen;

    function automatic logic [15:0] halt_motor(input logic [15:0] w, input logic [15:0] why);
        return w[ST_RUN_BIT] ? ((w & ~ST_RUN) | why) : w;
    endfunction

    function automatic logic [15:0] request_start(input logic [15:0] self,
                                                  input logic other_running,
                                                  input logic forward);
        logic [15:0] w;
        w = self;
        if (other_running) begin
            w = (w & ~ST_RES) | (16'(RES_BUSY) << 6);
        end else if (self[ST_RUN_BIT]) begin
            if (self[ST_DIR_BIT] == forward) begin
                w = (w & ~ST_RES) | (16'(RES_SAME) << 6);
            end else begin
                w = (w & ~ST_RES) | (16'(RES_REVERSE) << 6);
            end
        end else begin
            w = (self & ~(ST_CAUSES | ST_DIR)) | ST_RUN;
            if (forward) begin
                w = w | ST_DIR;
            end
        end
        return w;
    endfunction

    // Zero offset removed first; both limits and the displayed current use
    // the corrected count.
    function automatic logic [15:0] judge_current(input logic [15:0] self, input logic [2:0] gear,
                                                  input logic [2:0] og, input logic [7:0] sample);
        int          amps;
        int          stall_lim;
        int          open_lim;
        logic [31:0] shown;
        logic [15:0] w;
        w = self;
        if (self[ST_RUN_BIT]) begin
            amps = (sample > CUR_OFFSET) ? int'(sample) - int'(CUR_OFFSET) : 0;
            stall_lim = 108 + 27 * (int'(gear) - 1);
            open_lim = 11 * (int'(og) - 1) + 4;
            if (amps > stall_lim) begin
                w = (w & ~ST_RUN) | ST_OVER;
            end else if (amps < open_lim) begin
                w = (w & ~ST_RUN) | ST_OPEN;
            end
            shown = amps * 1087 / 1000;
            if (shown > 255) begin
                shown = 255;
            end
            w[15:8] = shown[7:0];
        end
        return w;
    endfunction

    task automatic model_event();
        logic [7:0]  words[4];
        logic [7:0]  c;
        logic [7:0]  delta;
        logic [31:0] volts;
        logic [31:0] secs;
        int          n;
        n = 0;
        c = i_cmd_byte;
        case (i_req_type)
            REQ_CMD: begin
                case (c[7:4])
                    GRP_VERSION: begin
                        words[0] = version_byte;
                        n = 1;
                    end
                    GRP_VOLT: begin
                        volts = 32'(i_bus_sample) * 34333 / 100000;
                        if (status_m1[ST_RUN_BIT] || status_m2[ST_RUN_BIT]) begin
                            volts = volts + 3;
                        end
                        words[0] = volts[7:0];
                        n = 1;
                    end
                    GRP_START1: begin
                        if (c == CMD_START1_FWD || c == CMD_START1_REV) begin
                            status_m1 = request_start(status_m1, status_m2[ST_RUN_BIT],
                                                      c == CMD_START1_FWD);
                            words[0] = status_m1[7:0];
                            words[1] = status_m1[15:8];
                            n = 2;
                        end
                    end
                    GRP_START2: begin
                        if (c[3:0] >= START2_LO && c[3:0] <= START2_HI) begin
                            // Even codes run forward, odd codes reverse.
                            status_m2 = request_start(status_m2, status_m1[ST_RUN_BIT], !c[0]);
                            words[0] = status_m2[7:0];
                            words[1] = status_m2[15:8];
                            n = 2;
                            if (c > CMD_START2_PLAIN) begin
                                secs = (32'(c) - 32'(CMD_START2_PLAIN) + 1) / 2 + 1;
                                fine_secs = secs[2:0];
                            end
                        end
                    end
                    GRP_MISC: begin
                        if (c == CMD_ZERO) begin
                            words[0] = 8'h00;
                            n = 1;
                        end else if (c == CMD_STATUS) begin
                            words[0] = status_m1[7:0];
                            words[1] = status_m1[15:8];
                            words[2] = status_m2[7:0];
                            words[3] = status_m2[15:8];
                            n = 4;
                        end else if (c == CMD_STOP) begin
                            status_m1 = halt_motor(status_m1, ST_CMD);
                            status_m2 = halt_motor(status_m2, ST_CMD);
                            words[0] = 8'h00;
                            n = 1;
                        end else if (c == CMD_GEAR_READ) begin
                            words[0] = {1'b0, gear_m2, 1'b0, gear_m1};
                            words[1] = {5'd0, open_gear_lvl};
                            n = 2;
                        end else if (c > CMD_GEAR2_BASE) begin
                            delta = c - CMD_GEAR2_BASE;
                            gear_m2 = delta[2:0];
                            words[0] = 8'h00;
                            n = 1;
                        end else begin
                            delta = c - CMD_GEAR_READ;
                            gear_m1 = delta[2:0];
                            words[0] = 8'h00;
                            n = 1;
                        end
                    end
                    GRP_OPEN: begin
                        if (c > CMD_OPEN_BASE) begin
                            delta = c - CMD_OPEN_BASE;
                            open_gear_lvl = delta[2:0];
                            words[0] = 8'h00;
                            n = 1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_CURRENT: begin
                if (i_motor_sel) begin
                    status_m2 = judge_current(status_m2, gear_m2, open_gear_lvl, i_current_sample);
                end else begin
                    status_m1 = judge_current(status_m1, gear_m1, open_gear_lvl, i_current_sample);
                end
            end
            REQ_UNDERVOLT: begin
                status_m1 = halt_motor(status_m1, ST_UV);
                status_m2 = halt_motor(status_m2, ST_UV);
            end
            default: begin
                if (fine_secs != 3'd0) begin
                    fine_secs = fine_secs - 3'd1;
                    if (fine_secs == 3'd0) begin
                        status_m1 = halt_motor(status_m1, ST_CMD);
                        status_m2 = halt_motor(status_m2, ST_CMD);
                    end
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            expected_replies.push_back(reply_word_t'{words[k], k == n - 1});
        end
    endtask

    task automatic note_error(input string why, input reply_word_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: reply word %0d %s:", $realtime, words_seen, why,
                     " expected byte 0x%02h last %0b,", want.data, want.last,
                     " got byte 0x%02h last %0b", i_reply_byte, i_last);
        end
    endtask

    always @(posedge i_clk) begin
        reply_word_t want;
        if (!i_rst_n) begin
            status_m1 = 16'h0000;
            status_m2 = 16'h0000;
            gear_m1 = GEAR_RESET;
            gear_m2 = GEAR_RESET;
            open_gear_lvl = GEAR_RESET;
            fine_secs = 3'd0;
            version_byte = VERSION_RESET;
            expected_replies.delete();
        end else begin
            // The supervisor keeps no boot gear registers, so their writes never
            // reach the gears; only the version byte matters.
            if (i_cfg_we && i_cfg_index == REG_VERSION) begin
                version_byte = i_cfg_data;
            end
            // Retire before predicting: a reply word never comes out on the
            // edge that accepts its own event.
            if (i_out_valid && i_out_ready) begin
                words_seen++;
                if (expected_replies.size() == 0) begin
                    want = '0;
                    note_error("with nothing expected", want);
                end else begin
                    want = expected_replies.pop_front();
                    if (i_reply_byte !== want.data || i_last !== want.last) begin
                        note_error("mismatch", want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                events_seen++;
                model_event();
            end
        end
        waiting_words <= expected_replies.size();
    end

endmodule

@@ tb/sv/tb_dual_motor_supervisor.sv @@
// ----------------------------------------------------------------------------
// tb_dual_motor_supervisor: testbench of the dual motor supervisor
// Drives command, current, undervoltage and tick events through a directed
// sequence and three randomized phases with different idle patterns on both
// channels, rewrites the registers between phases, and lets the reply
// checker judge every reply word against its own model of the motors.
// ----------------------------------------------------------------------------
module tb_dual_motor_supervisor
    import dms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 2;
    // The event queue is four deep and the executor pops it after acceptance,
    // so this drain time covers events that give no reply.
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_EVENTS   = 30;

    // The package only names the version register; the boot gears follow it.
    localparam logic [1:0] REG_BOOT_GEAR1 = 2'd1;
    localparam logic [1:0] REG_BOOT_GEAR2 = 2'd2;
    localparam logic [1:0] REG_BOOT_OPEN  = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = REG_VERSION;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_req_type = REQ_CMD;
    logic [7:0] i_cmd_byte = 8'h00;
    logic       i_motor_sel = 1'b0;
    logic [7:0] i_current_sample = 8'h00;
    logic [7:0] i_bus_sample = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_reply_byte;
    logic       o_last;

    int error_count;
    int words_pending;
    int events_accepted;
    int words_checked;

    // Percent of cycles in which the sender or the receiver holds back.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    dual_motor_supervisor u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_cmd_byte       (i_cmd_byte),
        .i_motor_sel      (i_motor_sel),
        .i_current_sample (i_current_sample),
        .i_bus_sample     (i_bus_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_reply_byte     (o_reply_byte),
        .o_last           (o_last)
    );

    dms_reply_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_cmd_byte       (i_cmd_byte),
        .i_motor_sel      (i_motor_sel),
        .i_current_sample (i_current_sample),
        .i_bus_sample     (i_bus_sample),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_reply_byte     (o_reply_byte),
        .i_last           (o_last),
        .o_errors         (error_count),
        .o_pending        (words_pending),
        .o_events         (events_accepted),
        .o_words          (words_checked)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    // The receiver decides afresh at every edge whether it takes a word.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // The watchdog only counts cycles in which neither channel moves a word,
    // so a long but healthy run never trips it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Presents one event word and returns in the time step of the edge that
    // accepts it. Valid is left high there: the next call either replaces the
    // payload or drops valid for a gap, so valid gets one update per step.
    task automatic send_event(input t_req kind, input logic [7:0] cmd, input logic sel,
                              input logic [7:0] cur, input logic [7:0] bus);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_cmd_byte <= cmd;
        i_motor_sel <= sel;
        i_current_sample <= cur;
        i_bus_sample <= bus;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Fields that the event kind does not use still carry random values, so
    // the block sees them toggle without acting on them.
    task automatic send_cmd(input logic [7:0] cmd);
        send_event(REQ_CMD, cmd, 1'($urandom_range(1)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    endtask

    task automatic send_sample(input logic sel, input logic [7:0] cur);
        send_event(REQ_CURRENT, 8'($urandom_range(255)), sel, cur, 8'($urandom_range(255)));
    endtask

    task automatic send_plain(input t_req kind);
        send_event(kind, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // The sender holds off until every reply word predicted so far has been
    // taken. The counter is registered, so an edge is let pass first; it can
    // only fall while no event is being sent.
    task automatic hold_off_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Idle for register writes: all replies taken and events that give no
    // reply worked off inside the block as well.
    task automatic quiesce();
        hold_off_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] ver, input logic [2:0] g1,
                                input logic [2:0] g2, input logic [2:0] og);
        put_reg(REG_VERSION, ver);
        put_reg(REG_BOOT_GEAR1, {5'd0, g1});
        put_reg(REG_BOOT_GEAR2, {5'd0, g2});
        put_reg(REG_BOOT_OPEN, {5'd0, og});
        i_cfg_we <= 1'b0;
    endtask

    // Most commands are well formed so that motors start, run and hit their
    // limits; a few are arbitrary bytes. The misc group holds the stop
    // command, which keeps stops by command rare.
    function automatic logic [7:0] pick_command();
        logic [3:0] nib;
        logic [7:0] c;
        nib = 4'($urandom_range(15));
        case ($urandom_range(11))
            0, 1, 2: c = $urandom_range(1) ? CMD_START1_FWD : CMD_START1_REV;
            3, 4, 5: begin
                nib = 4'($urandom_range(START2_HI, START2_LO));
                c = {GRP_START2, nib};
            end
            6:       c = {GRP_VERSION, nib};
            7:       c = {GRP_VOLT, nib};
            8, 9:    c = {GRP_MISC, nib};
            10:      c = {GRP_OPEN, nib};
            default: c = 8'($urandom_range(255));
        endcase
        return c;
    endfunction

    // Half of the samples fall in the band that passes every gear pair, so
    // running motors tend to stay running; the rest probe the limits.
    function automatic logic [7:0] pick_sample();
        logic [7:0] s;
        case ($urandom_range(3))
            0:       s = 8'($urandom_range(255));
            1, 2:    s = 8'($urandom_range(113, 65));
            default: s = 8'($urandom_range(1) ? $urandom_range(12) : $urandom_range(255, 236));
        endcase
        return s;
    endfunction

    task automatic random_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 48) begin
            send_cmd(pick_command());
        end else if (pick < 78) begin
            send_sample(1'($urandom_range(1)), pick_sample());
        end else if (pick < 84) begin
            send_plain(REQ_UNDERVOLT);
        end else begin
            send_plain(REQ_TICK);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (PHASE_EVENTS) begin
            random_event();
            if ($urandom_range(24) == 0) begin
                hold_off_until_drained();
            end
        end
    endtask

    initial begin
        logic [2:0] mid_gear;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence, run at the reset register values with light
        // idling on both sides.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_cmd({GRP_VERSION, 4'h0});
        send_event(REQ_CMD, {GRP_VOLT, 4'hF}, 1'b0, 8'h00, 8'hFF);
        // A sample for a motor that is not running changes nothing.
        send_sample(1'b0, 8'hFF);
        // Start the first motor, then ask again in the same and the reverse
        // direction, then try the second motor while the first one runs.
        send_cmd(CMD_START1_FWD);
        send_cmd(CMD_START1_FWD);
        send_cmd(CMD_START1_REV);
        send_cmd({GRP_START2, START2_LO});
        // The voltage reading adds its offset while a motor runs.
        send_event(REQ_CMD, {GRP_VOLT, 4'h0}, 1'b1, 8'hFF, 8'h00);
        // Overcurrent at full scale, restart, then open circuit on a sample
        // at or below the zero offset.
        send_sample(1'b0, 8'hFF);
        send_cmd(CMD_START1_REV);
        send_sample(1'b0, CUR_OFFSET - 8'd2);
        // Gear settings at their extremes, read back.
        send_cmd(CMD_GEAR2_BASE);
        send_cmd(CMD_GEAR2_BASE + 8'd1);
        send_cmd({GRP_MISC, 4'hF});
        send_cmd(CMD_OPEN_BASE + 8'd1);
        send_cmd({GRP_OPEN, 4'hF});
        send_cmd(CMD_GEAR_READ);
        // Bytes next to valid codes that must be ignored.
        send_cmd(CMD_OPEN_BASE);
        send_cmd({GRP_START2, START2_HI} + 8'd1);
        // Second motor with the longest fine-adjust countdown; a sample right
        // on the highest overcurrent limit keeps it running with a saturated
        // current field.
        send_cmd({GRP_START2, START2_HI});
        send_sample(1'b1, 8'd248);
        send_cmd(CMD_STATUS);
        hold_off_until_drained();
        // The countdown runs out on the sixth tick and stops the motor.
        repeat (6) send_plain(REQ_TICK);
        send_cmd(CMD_START1_FWD);
        send_plain(REQ_UNDERVOLT);
        send_cmd(CMD_STOP);
        send_cmd(CMD_ZERO);
        send_cmd(CMD_STATUS);
        quiesce();

        // Random phases, each after a register rewrite: lowest version with highest
        // gears first, the reverse next, then a random setting. The block keeps no
        // boot gear registers, so their writes leave the gears alone.
        program_regs(8'h00, 3'd6, 3'd6, 3'd6);
        run_phase(35, 54);
        quiesce();
        program_regs(8'hFF, 3'd1, 3'd1, 3'd1);
        run_phase(54, 35);
        quiesce();
        mid_gear = 3'($urandom_range(6, 1));
        program_regs(8'($urandom_range(255)), mid_gear, 3'd7 - mid_gear, mid_gear);
        run_phase(0, 0);

        // Let every predicted word arrive, then give late or extra words a
        // chance to show up before the verdict.
        quiesce();
        $display("Run covered %0d events: directed cases, then three random phases",
                 events_accepted);
        $display("with different idle patterns and register settings; %0d reply words checked",
                 words_checked);
        if (error_count == 0 && words_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
